[hw/rtl/ppid_pkg.sv]
// Shared types, register map and constants for the pitch PID elevator block.
`default_nettype none

package ppid_pkg;

    // APB register map (word index = paddr[4:2])
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [2:0] REG_TIME_STEP    = 3'd3;
    localparam logic [2:0] REG_TORQUE_SCALE = 3'd4;

    localparam logic [15:0] PROP_GAIN_RST    = 16'd2560;
    localparam logic [15:0] INTEG_GAIN_RST   = 16'd2560;
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd512;
    localparam logic [15:0] TIME_STEP_RST    = 16'd655;
    localparam logic [31:0] TORQUE_SCALE_RST = 32'd65536;

    // Integrator upper clamp: 0.5 in Q3.28
    localparam logic signed [34:0] INTEG_UPPER = 35'sd134217728;
    localparam logic signed [34:0] INTEG_LOWER = -35'sd2147483648;

    // Deflection limit: 0.28 rad in Q3.12
    localparam logic [10:0] DEFL_LIMIT = 11'd1147;

    // Quotient bits produced by the divider (quotients >= 2^DIV_BITS saturate)
    localparam int unsigned DIV_BITS = 11;

    typedef struct packed {
        logic signed [15:0] pitch_setpoint;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] pitch_rate;
        logic        [15:0] air_speed;
    } tick_t;

    typedef struct packed {
        logic signed [11:0] deflection;
        logic signed [31:0] accel_command;
    } result_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [15:0] time_step;
        logic [31:0] torque_scale;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_INTEG,
        ST_MUL2,
        ST_SUM,
        ST_ACC,
        ST_NUM,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic integ;
        logic mul2;
        logic sum;
        logic acc;
        logic num;
        logic chk;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_div;
    } stat_t;

endpackage : ppid_pkg

`default_nettype wire

[hw/rtl/pitch_pid_to_elevator_deflection_top.sv]
// Top level of the pitch PID to elevator deflection block.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------
//   tick     | tick_valid / tick_ready   | tick   (ppid_pkg::tick_t)
//   result   | result_valid/result_ready | result (ppid_pkg::result_t)
//   config   | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// After the accepting edge a request steps through MUL1, INTEG, MUL2, SUM, ACC,
// NUM and CHK, then the one-bit-a-cycle restoring divider (DIV), then DONE, which
// loads the result register and sets result valid. DIV is skipped when the quotient
// is settled without it (zero command or torque scale, zero airspeed or saturation).
// The next request is taken in the idle state that follows. A result held by a
// stalled consumer stalls the controller only at its last step, one result register deep.
// Reset (rst_n low, asynchronous) restores the gains and clears the integrator.
// Writing any gain register also clears the integrator.
`default_nettype none

module pitch_pid_to_elevator_deflection_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppid_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ppid_pkg::DATA_W-1:0]   pwdata,
    output logic      [ppid_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // control tick in
    input  wire logic                          tick_valid,
    output logic                               tick_ready,
    input  wire ppid_pkg::tick_t               tick,
    // deflection out
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output ppid_pkg::result_t                  result
);
    import ppid_pkg::*;

    cfg_t  cfg;
    logic  gain_wr;
    cmd_t  cmd;
    stat_t status;

    // Register file; the user must see that gain writes only happen while idle (unchecked by the block)
    ppid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .gain_wr (gain_wr)
    );

    // Sequencer: one request at a time, owns the result valid flag
    ppid_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Multipliers, integrator, Q.36 sum and divider
    ppid_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .gain_wr (gain_wr),
        .tick    (tick),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule : pitch_pid_to_elevator_deflection_top

`default_nettype wire

[hw/rtl/ppid_regs.sv]
// APB configuration registers for the pitch PID block.
`default_nettype none

module ppid_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppid_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ppid_pkg::DATA_W-1:0]   pwdata,
    output logic      [ppid_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output ppid_pkg::cfg_t                     cfg,
    output logic                               gain_wr
);
    import ppid_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // any gain write restarts the integrator
    assign gain_wr = wr_en && (idx == REG_PROP_GAIN || idx == REG_INTEG_GAIN
                               || idx == REG_DERIV_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= PROP_GAIN_RST;
            cfg_reg.integ_gain   <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain   <= DERIV_GAIN_RST;
            cfg_reg.time_step    <= TIME_STEP_RST;
            cfg_reg.torque_scale <= TORQUE_SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= pwdata[15:0];
                REG_INTEG_GAIN:   cfg_reg.integ_gain   <= pwdata[15:0];
                REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= pwdata[15:0];
                REG_TIME_STEP:    cfg_reg.time_step    <= pwdata[15:0];
                REG_TORQUE_SCALE: cfg_reg.torque_scale <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:    prdata = {16'd0, cfg_reg.prop_gain};
            REG_INTEG_GAIN:   prdata = {16'd0, cfg_reg.integ_gain};
            REG_DERIV_GAIN:   prdata = {16'd0, cfg_reg.deriv_gain};
            REG_TIME_STEP:    prdata = {16'd0, cfg_reg.time_step};
            REG_TORQUE_SCALE: prdata = cfg_reg.torque_scale;
            default:          prdata = '0;
        endcase
    end

endmodule : ppid_regs

`default_nettype wire

[hw/rtl/ppid_ctrl.sv]
// Sequencing state machine for the pitch PID block.
`default_nettype none

module ppid_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tick_valid,
    output logic                 tick_ready,
    output logic                 result_valid,
    input  wire logic            result_ready,
    input  wire ppid_pkg::stat_t status,
    output ppid_pkg::cmd_t       cmd
);
    import ppid_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_BITS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rvalid_reg, rvalid_next;
    logic               out_free;

    assign out_free     = !rvalid_reg || result_ready;
    assign result_valid = rvalid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (tick_valid) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_NUM;
            ST_NUM:   state_next = ST_CHK;
            ST_CHK:   state_next = status.need_div ? ST_DIV : ST_DONE;
            ST_DIV:   if (cnt_reg == CNT_W'(DIV_BITS - 1)) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        tick_ready   = 1'b0;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                cmd.load   = tick_valid;
            end
            ST_MUL1:  cmd.mul1  = 1'b1;
            ST_INTEG: cmd.integ = 1'b1;
            ST_MUL2:  cmd.mul2  = 1'b1;
            ST_SUM:   cmd.sum   = 1'b1;
            ST_ACC:   cmd.acc   = 1'b1;
            ST_NUM:   cmd.num   = 1'b1;
            ST_CHK:
            begin
                cmd.chk  = 1'b1;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_DONE:  cmd.out_load = out_free;
            default:  ;
        endcase
        rvalid_next = cmd.out_load ? 1'b1 : (result_ready ? 1'b0 : rvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

endmodule : ppid_ctrl

`default_nettype wire

[hw/rtl/ppid_dpath.sv]
// Arithmetic datapath: integrator, PID sum and restoring divider.
`default_nettype none

module ppid_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ppid_pkg::cfg_t    cfg,
    input  wire logic              gain_wr,
    input  wire ppid_pkg::tick_t   tick,
    input  wire ppid_pkg::cmd_t    cmd,
    output ppid_pkg::stat_t        status,
    output ppid_pkg::result_t      result
);
    import ppid_pkg::*;

    localparam int unsigned DEN_W = 36;                // v^2 * 16
    localparam int unsigned REM_W = DEN_W + DIV_BITS;  // remainder below den << 11
    localparam int unsigned DSR_W = DEN_W + DIV_BITS - 1;

    // operands
    logic signed [16:0]       err_reg;
    logic signed [15:0]       rate_reg;
    logic        [15:0]       speed_reg;
    // first products
    logic signed [33:0]       incr_reg;
    logic signed [33:0]       pterm_reg;
    logic signed [32:0]       dterm_reg;
    logic        [31:0]       vsq_reg;
    // integrator, Q3.28
    logic signed [31:0]       integral_reg;
    logic signed [34:0]       integ_sum;
    logic signed [31:0]       integral_next;
    // command
    logic signed [48:0]       iterm_reg;
    logic signed [51:0]       sum_reg;
    logic signed [51:0]       rnd;
    logic signed [31:0]       acc_reg;
    // deflection
    logic                     neg_reg;
    logic        [31:0]       amag;
    logic        [63:0]       num_reg;
    logic        [DEN_W-1:0]  den_reg;
    logic        [REM_W-1:0]  rem_reg;
    logic        [DSR_W-1:0]  dsr_reg;
    logic        [DIV_BITS-1:0] q_reg;
    logic                     trial_ok;
    logic        [10:0]       mag;
    result_t                  result_reg;

    assign result = result_reg;

    // quotient fits in DIV_BITS only if num < den << DIV_BITS
    assign status.need_div = (num_reg != '0) && (den_reg != '0)
                             && (num_reg < {17'd0, den_reg, {DIV_BITS{1'b0}}});

    always_comb
    begin
        integ_sum = 35'(integral_reg) + 35'(incr_reg);
        if (integ_sum > INTEG_UPPER)
            integral_next = INTEG_UPPER[31:0];
        else if (integ_sum < INTEG_LOWER)
            integral_next = INTEG_LOWER[31:0];
        else
            integral_next = integ_sum[31:0];
    end

    assign rnd      = sum_reg + 52'sd524288;   // half LSB of Q.16
    assign amag     = acc_reg[31] ? 32'(-acc_reg) : acc_reg;
    assign trial_ok = rem_reg >= {1'b0, dsr_reg};
    assign mag      = (q_reg > DEFL_LIMIT) ? DEFL_LIMIT : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integral_reg <= '0;
        else if (gain_wr)
            integral_reg <= '0;
        else if (cmd.integ)
            integral_reg <= integral_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg   <= 17'(tick.pitch_setpoint) - 17'(tick.pitch_angle);
            rate_reg  <= tick.pitch_rate;
            speed_reg <= tick.air_speed;
        end
        if (cmd.mul1)
        begin
            incr_reg  <= err_reg * $signed({1'b0, cfg.time_step});
            pterm_reg <= err_reg * $signed({1'b0, cfg.prop_gain});
            dterm_reg <= rate_reg * $signed({1'b0, cfg.deriv_gain});
            vsq_reg   <= speed_reg * speed_reg;
        end
        if (cmd.mul2)
            iterm_reg <= integral_reg * $signed({1'b0, cfg.integ_gain});
        if (cmd.sum)
            sum_reg <= {{2{pterm_reg[33]}}, pterm_reg, 16'd0}
                     - {{3{dterm_reg[32]}}, dterm_reg, 16'd0}
                     + {{3{iterm_reg[48]}}, iterm_reg};
        if (cmd.acc)
            acc_reg <= rnd[51:20];             // |sum| < 2^50, so no saturation
        if (cmd.num)
        begin
            neg_reg <= acc_reg[31];
            num_reg <= cfg.torque_scale * amag;
            den_reg <= {vsq_reg, 4'd0};
        end
        if (cmd.chk)
        begin
            rem_reg <= num_reg[REM_W-1:0];
            dsr_reg <= {den_reg, {(DIV_BITS-1){1'b0}}};
            if (num_reg == '0)
                q_reg <= '0;
            else if (!status.need_div)
                q_reg <= DIV_BITS'(DEFL_LIMIT);   // zero airspeed or huge ratio
            else
                q_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (trial_ok)
                rem_reg <= rem_reg - {1'b0, dsr_reg};
            q_reg   <= {q_reg[DIV_BITS-2:0], trial_ok};
            dsr_reg <= dsr_reg >> 1;
        end
        if (cmd.out_load)
        begin
            result_reg.accel_command <= acc_reg;
            result_reg.deflection    <= neg_reg ? $signed({1'b0, mag})
                                                : -$signed({1'b0, mag});
        end
    end

endmodule : ppid_dpath

`default_nettype wire

[hw/rtl/ppid_checker.sv]
// Port-level checker for the pitch PID block, bound to the top level.
`default_nettype none

module ppid_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                tick_valid,
    input wire logic                tick_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire ppid_pkg::result_t   result
);
    import ppid_pkg::*;

    logic [1:0] pend_reg;
    logic       t_acc;
    logic       r_acc;

    assign t_acc = tick_valid && tick_ready;
    assign r_acc = result_valid && result_ready;

    // requests accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + {1'b0, t_acc} - {1'b0, r_acc};
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests in flight");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.deflection <= 12'sd1147
                      && result.deflection >= -12'sd1147)
        else $error("deflection beyond limit");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.accel_command > 32'sd0 |-> result.deflection <= 12'sd0)
        else $error("deflection sign not opposite to command");

endmodule : ppid_checker

bind pitch_pid_to_elevator_deflection_top ppid_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[sim/pitch_pid_to_elevator_deflection_top_tb.sv]
// Self-checking testbench for the pitch PID to elevator deflection block.
`timescale 1ns / 100ps

module pitch_pid_to_elevator_deflection_top_tb;

    import ppid_pkg::*;

    // Register index with nothing behind it; a write there must change nothing
    localparam logic [2:0] REG_UNUSED    = 3'd5;
    localparam longint     INTEG_CEILING = 64'sd134217728;   // 0.5 in Q3.28
    localparam int         DEFL_MAX      = 1147;             // 0.28 rad in Q3.12
    localparam int         IDLE_PCT      = 13;
    localparam int         RANDOM_PHASES = 6;
    localparam int         PHASE_TICKS   = 122;
    localparam int         STALL_LIMIT   = 3000;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_W-1:0]      paddr        = '0;
    logic [DATA_W-1:0]      pwdata       = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   tick_valid   = 1'b0;
    logic                   tick_ready;
    tick_t                  tick         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;

    // Predictor state: register shadow and the integrator copy
    cfg_t                   ctrl_cfg;
    int                     pitch_error_sum;

    tick_t                  pending_ticks[$];
    result_t                expected_deflections[$];
    int                     mismatch_count = 0;
    int                     results_seen   = 0;
    int                     quiet_cycles   = 0;
    // Set for one phase: neither side idles, so the block runs flat out
    logic                   steady         = 1'b0;

    pitch_pid_to_elevator_deflection_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int clamp_to_int(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return int'(x);
    endfunction

    // Reset values of the register file; the integrator starts at zero
    function automatic void restore_defaults();
        ctrl_cfg.prop_gain    = PROP_GAIN_RST;
        ctrl_cfg.integ_gain   = INTEG_GAIN_RST;
        ctrl_cfg.deriv_gain   = DERIV_GAIN_RST;
        ctrl_cfg.time_step    = TIME_STEP_RST;
        ctrl_cfg.torque_scale = TORQUE_SCALE_RST;
        pitch_error_sum       = 0;
    endfunction

    // Any gain write clears the integrator; time step and torque scale do not
    function automatic void apply_register(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_PROP_GAIN:
            begin
                ctrl_cfg.prop_gain = value[15:0];
                pitch_error_sum    = 0;
            end
            REG_INTEG_GAIN:
            begin
                ctrl_cfg.integ_gain = value[15:0];
                pitch_error_sum     = 0;
            end
            REG_DERIV_GAIN:
            begin
                ctrl_cfg.deriv_gain = value[15:0];
                pitch_error_sum     = 0;
            end
            REG_TIME_STEP:    ctrl_cfg.time_step    = value[15:0];
            REG_TORQUE_SCALE: ctrl_cfg.torque_scale = value;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(logic [2:0] idx);
        case (idx)
            REG_PROP_GAIN:    return {16'd0, ctrl_cfg.prop_gain};
            REG_INTEG_GAIN:   return {16'd0, ctrl_cfg.integ_gain};
            REG_DERIV_GAIN:   return {16'd0, ctrl_cfg.deriv_gain};
            REG_TIME_STEP:    return {16'd0, ctrl_cfg.time_step};
            REG_TORQUE_SCALE: return ctrl_cfg.torque_scale;
            default:          return 32'd0;
        endcase
    endfunction

    // One control tick: integrate, form the command, scale by 1/v^2 and clamp
    function automatic result_t predict_deflection(tick_t t);
        longint             err;
        longint             integ_next;
        longint             q36;
        longint             acc_wide;
        int                 acc;
        logic [63:0]        amag;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        mag;
        logic signed [11:0] mag12;
        result_t            r;

        err        = longint'($signed(t.pitch_setpoint)) - longint'($signed(t.pitch_angle));
        integ_next = longint'(pitch_error_sum) + err * longint'(ctrl_cfg.time_step);
        if (integ_next > INTEG_CEILING)
            integ_next = INTEG_CEILING;
        pitch_error_sum = clamp_to_int(integ_next);

        // Command summed in Q.36, rounded half up to Q.16
        q36 = longint'(ctrl_cfg.prop_gain) * err * 64'sd65536
            - longint'(ctrl_cfg.deriv_gain) * longint'($signed(t.pitch_rate)) * 64'sd65536
            + longint'(ctrl_cfg.integ_gain) * longint'(pitch_error_sum);
        acc_wide = (q36 + 64'sd524288) >>> 20;
        acc      = clamp_to_int(acc_wide);

        amag = (acc < 0) ? 64'(-longint'(acc)) : 64'(longint'(acc));
        num  = {32'd0, ctrl_cfg.torque_scale} * amag;
        if (num == 64'd0)
            mag = 64'd0;
        else
        begin
            den = ({48'd0, t.air_speed} * {48'd0, t.air_speed}) << 4;
            // zero airspeed saturates by the sign of the command
            if (den == 64'd0)
                mag = 64'(DEFL_MAX);
            else
            begin
                mag = num / den;
                if (mag > 64'(DEFL_MAX))
                    mag = 64'(DEFL_MAX);
            end
        end
        mag12           = mag[11:0];
        r.deflection    = (acc < 0) ? mag12 : -mag12;
        r.accel_command = acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_tick(int sp, int ang, int rate, int air);
        tick_t t;
        t.pitch_setpoint = 16'(sp);
        t.pitch_angle    = 16'(ang);
        t.pitch_rate     = 16'(rate);
        t.air_speed      = 16'(air);
        pending_ticks.push_back(t);
    endtask

    // Mostly plausible flight conditions, with raw noise and edge airspeeds
    task automatic queue_random_tick();
        int roll;
        int air;
        roll = $urandom_range(99);
        if (roll < 60)
            queue_tick(int'($urandom_range(4096)) - 2048, int'($urandom_range(4096)) - 2048,
                       int'($urandom_range(8192)) - 4096, $urandom_range(20480, 1280));
        else if (roll < 85)
            queue_tick($urandom, $urandom, $urandom, $urandom);
        else
        begin
            case ($urandom_range(3))
                0:       air = 0;
                1:       air = 1;
                2:       air = 65535;
                default: air = $urandom_range(255);
            endcase
            queue_tick($urandom, $urandom, $urandom, air);
        end
    endtask

    function automatic logic [15:0] random_gain();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 256));
    endfunction

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_until_idle();
        while (pending_ticks.size() != 0 || tick_valid || expected_deflections.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(logic [2:0] idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== register_value(idx))
            report_mismatch($sformatf("register %0d reads %h, want %h",
                                      idx, prdata, register_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_all_regs();
        check_reg(REG_PROP_GAIN);
        check_reg(REG_INTEG_GAIN);
        check_reg(REG_DERIV_GAIN);
        check_reg(REG_TIME_STEP);
        check_reg(REG_TORQUE_SCALE);
    endtask

    task automatic report_mismatch(string what);
        // keep the log short if everything goes wrong
        if (mismatch_count < 40)
            $display("[%0t] result %0d: %s", $realtime, results_seen, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Tick driver: offers the queued requests, idling now and then.
    // The expectation is formed at the edge that accepts the request, so
    // the predictor sees requests in exactly the order the block does.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            tick       <= '0;
        end
        else
        begin
            if (tick_valid && tick_ready)
                expected_deflections.push_back(predict_deflection(tick));
            // a held request stays put until taken
            if (!tick_valid || tick_ready)
            begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    tick       <= pending_ticks.pop_front();
                    tick_valid <= 1'b1;
                end
                else
                    tick_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each result against the oldest expectation, field by
    // field; ready drops at random to back-pressure the block.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_deflections.size() == 0)
                    report_mismatch("result arrived with no request outstanding");
                else
                begin
                    want = expected_deflections.pop_front();
                    if (result.deflection !== want.deflection)
                        report_mismatch($sformatf("deflection %0d, want %0d",
                                                  result.deflection, want.deflection));
                    if (result.accel_command !== want.accel_command)
                        report_mismatch($sformatf("accel_command %0d, want %0d",
                                                  result.accel_command, want.accel_command));
                end
            end
            result_ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Watchdog: too long with no request or result moving means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_valid && tick_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("pitch_pid_to_elevator_deflection_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed ticks on the reset gains, then phases of
    // random ticks, each under a fresh register setting written while idle.
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int n;

        restore_defaults();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        check_all_regs();

        // Directed: zero airspeed with zero, positive and negative command
        queue_tick(0, 0, 0, 0);
        queue_tick(32767, -32768, -32768, 0);
        queue_tick(-32768, 32767, 32767, 0);
        // field extremes and the airspeed range ends
        queue_tick(32767, -32768, 32767, 65535);
        queue_tick(-32768, 32767, -32768, 65535);
        queue_tick(-32768, -32768, 0, 1);
        queue_tick(32767, 32767, 0, 1);
        queue_tick(0, 0, 0, 2560);
        // integrator driven into its upper clamp
        for (n = 0; n < 6; n++)
            queue_tick(32767, -32768, 0, 7680);
        queue_tick(0, 0, 0, 7680);
        // gentle flight points
        queue_tick(410, 0, 100, 5120);
        queue_tick(-410, 205, -300, 10240);
        queue_tick(1024, 1000, 4096, 20480);
        queue_tick(-2048, 2048, 0, 1280);
        queue_tick(0, 4096, -4096, 256);
        wait_until_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // every register at its top end
                    write_reg(REG_PROP_GAIN, 32'h0000FFFF);
                    write_reg(REG_INTEG_GAIN, 32'h0000FFFF);
                    write_reg(REG_DERIV_GAIN, 32'h0000FFFF);
                    write_reg(REG_TIME_STEP, 32'h0000FFFF);
                    write_reg(REG_TORQUE_SCALE, 32'hFFFFFFFF);
                end
                1:
                begin
                    // every register at zero
                    write_reg(REG_PROP_GAIN, 32'd0);
                    write_reg(REG_INTEG_GAIN, 32'd0);
                    write_reg(REG_DERIV_GAIN, 32'd0);
                    write_reg(REG_TIME_STEP, 32'd0);
                    write_reg(REG_TORQUE_SCALE, 32'd0);
                end
                2:
                begin
                    // plausible gains, then only the non-gain registers change,
                    // so the integrator is carried over
                    write_reg(REG_PROP_GAIN, {16'd0, random_gain()});
                    write_reg(REG_INTEG_GAIN, {16'd0, random_gain()});
                    write_reg(REG_DERIV_GAIN, {16'd0, random_gain()});
                    write_reg(REG_TIME_STEP, {16'd0, TIME_STEP_RST});
                    write_reg(REG_TORQUE_SCALE, TORQUE_SCALE_RST);
                    for (n = 0; n < 20; n++)
                        queue_random_tick();
                    wait_until_idle();
                    write_reg(REG_TIME_STEP, $urandom_range(4000, 100));
                    write_reg(REG_TORQUE_SCALE, $urandom_range(1 << 20, 1 << 14));
                end
                default:
                begin
                    // random subset, plus a write to an empty slot
                    if ($urandom_range(1))
                        write_reg(REG_PROP_GAIN, {16'd0, random_gain()});
                    if ($urandom_range(1))
                        write_reg(REG_INTEG_GAIN, {16'd0, random_gain()});
                    if ($urandom_range(1))
                        write_reg(REG_DERIV_GAIN, {16'd0, random_gain()});
                    if ($urandom_range(1))
                        write_reg(REG_TIME_STEP, ($urandom_range(3) == 0) ?
                                  $urandom_range(65535) : $urandom_range(2000, 100));
                    if ($urandom_range(1))
                        write_reg(REG_TORQUE_SCALE, ($urandom_range(3) == 0) ?
                                  $urandom : $urandom_range(1 << 20, 1 << 14));
                    write_reg(REG_UNUSED, $urandom);
                end
            endcase
            check_all_regs();

            steady = (ph == 2);
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                queue_random_tick();
                // hold the sender mid-phase until the block has drained
                if (ph == 3 && n == PHASE_TICKS / 2)
                    wait_until_idle();
            end
            wait_until_idle();
            steady = 1'b0;
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("pitch_pid_to_elevator_deflection_top: match");
        else
            $display("pitch_pid_to_elevator_deflection_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ppid_pkg.sv
hw/rtl/ppid_regs.sv
hw/rtl/ppid_ctrl.sv
hw/rtl/ppid_dpath.sv
hw/rtl/pitch_pid_to_elevator_deflection_top.sv
hw/rtl/ppid_checker.sv
sim/pitch_pid_to_elevator_deflection_top_tb.sv
